// File: design/ies_pkg.sv
// Shared types and constants for the image extrema statistics block.
// No dependencies.
package ies_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned CoordW = 12;
  localparam int unsigned CfgW   = 13;
  localparam int unsigned SumW   = 10;

  localparam logic [CfgW-1:0]   WidthReset = 13'd640;
  localparam logic [CfgW-1:0]   WidthCap   = CfgW'(MaxWidth);
  localparam logic [CoordW-1:0] RowLast    = CoordW'(MaxHeight - 1);
  localparam logic [ChanW-1:0]  ChanFull   = 8'd255;

  typedef enum logic [1:0] {
    KindHighSum = 2'd0,
    KindLowSum  = 2'd1,
    KindChanMax = 2'd2,
    KindChanMin = 2'd3
  } ies_kind_e;

  typedef logic [2:0][ChanW-1:0] ies_color_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } ies_place_t;

  typedef struct packed {
    ies_place_t high_place;
    ies_color_t high_color;
    ies_place_t low_place;
    ies_color_t low_color;
    ies_color_t chan_max;
    ies_color_t chan_min;
  } ies_report_t;

endpackage

// File: design/image_extrema_statistics.sv
// Image extrema statistics: top level with width register and report buffer.
// Throughput one pixel per cycle; the four report records follow the last pixel from the
// next cycle on, one per cycle while the consumer is ready. A last pixel waits while the
// previous report is still draining; other pixels keep flowing meanwhile.
// Reset clears all frame state and sets image width to 640.
// Depends on ies_pkg and ies_stats.
module image_extrema_statistics import ies_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ChanW-1:0]  red_i,
  input  logic [ChanW-1:0]  green_i,
  input  logic [ChanW-1:0]  blue_i,
  input  logic              last_pixel_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        record_kind_o,
  output logic [CoordW-1:0] pos_x_o,
  output logic [CoordW-1:0] pos_y_o,
  output logic [ChanW-1:0]  out_red_o,
  output logic [ChanW-1:0]  out_green_o,
  output logic [ChanW-1:0]  out_blue_o,
  output logic              last_record_o
);

  logic [CfgW-1:0] image_width_q;
  logic            full_q, full_d;
  logic [1:0]      idx_q, idx_d;
  ies_report_t     snap_q;
  ies_report_t     report;
  ies_color_t      pixel;
  ies_place_t      sel_place;
  ies_color_t      sel_color;
  logic            in_xfer, out_xfer, load;

  assign pixel      = {blue_i, green_i, red_i};
  assign in_ready_o = !(full_q && last_pixel_i);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign load       = in_xfer && last_pixel_i;
  assign out_xfer   = out_valid_o && out_ready_i;

  ies_stats u_stats (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (in_xfer),
    .pixel_i       (pixel),
    .last_i        (last_pixel_i),
    .image_width_i (image_width_q),
    .report_o      (report)
  );

  always_comb begin
    full_d = full_q;
    idx_d  = idx_q;
    if (out_xfer) begin
      idx_d = idx_q + 2'd1;
      if (ies_kind_e'(idx_q) == KindChanMin) begin
        full_d = 1'b0;
      end
    end
    if (load) begin
      full_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= WidthReset;
      full_q        <= 1'b0;
      idx_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        image_width_q <= cfg_wdata_i;
      end
      full_q <= full_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      snap_q <= report;
    end
  end

  always_comb begin
    sel_place = '0;
    sel_color = '0;
    unique case (ies_kind_e'(idx_q))
      KindHighSum: begin
        sel_place = snap_q.high_place;
        sel_color = snap_q.high_color;
      end
      KindLowSum: begin
        sel_place = snap_q.low_place;
        sel_color = snap_q.low_color;
      end
      KindChanMax: sel_color = snap_q.chan_max;
      KindChanMin: sel_color = snap_q.chan_min;
      default: ;
    endcase
  end

  assign out_valid_o   = full_q;
  assign record_kind_o = idx_q;
  assign pos_x_o       = sel_place.x;
  assign pos_y_o       = sel_place.y;
  assign out_red_o     = sel_color[0];
  assign out_green_o   = sel_color[1];
  assign out_blue_o    = sel_color[2];
  assign last_record_o = (ies_kind_e'(idx_q) == KindChanMin);

  a_report_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_o && ies_kind_e'(record_kind_o) == KindHighSum))
    else $error("report did not start after last pixel");

  a_report_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && last_record_o) |=> !out_valid_o)
    else $error("output still valid after final record");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_valid_i && last_pixel_i) |-> !in_ready_o)
    else $error("last pixel accepted over a pending report");

  a_first_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ies_kind_e'(record_kind_o) == KindHighSum)
    else $error("report did not start with the max-sum record");

endmodule

// File: design/ies_stats.sv
// Frame accumulator: column/row counting, sum extrema and channel extrema.
// Depends on ies_pkg.
module ies_stats import ies_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  ies_color_t            pixel_i,
  input  logic                  last_i,
  input  logic [CfgW-1:0]       image_width_i,
  output ies_report_t           report_o
);

  logic              empty_q, empty_d;
  logic [CoordW-1:0] col_q, col_d;
  logic [CoordW-1:0] row_q, row_d;
  logic [SumW-1:0]   high_sum_q, high_sum_d;
  logic [SumW-1:0]   low_sum_q, low_sum_d;
  ies_place_t        high_place_q, high_place_d;
  ies_place_t        low_place_q, low_place_d;
  ies_color_t        high_color_q, high_color_d;
  ies_color_t        low_color_q, low_color_d;
  ies_color_t        max_q, max_d;
  ies_color_t        min_q, min_d;

  logic [SumW-1:0]   sum;
  logic [CfgW-1:0]   width_eff;
  logic [CfgW-1:0]   col_inc;
  ies_place_t        place;
  ies_report_t       upd;

  always_comb begin
    sum = SumW'(pixel_i[0]) + SumW'(pixel_i[1]) + SumW'(pixel_i[2]);
    place.x = col_q;
    place.y = row_q;

    width_eff = image_width_i;
    if (image_width_i == '0) begin
      width_eff = CfgW'(1);
    end else if (image_width_i > WidthCap) begin
      width_eff = WidthCap;
    end
    col_inc = CfgW'(col_q) + CfgW'(1);

    upd.high_place = high_place_q;
    upd.high_color = high_color_q;
    high_sum_d     = high_sum_q;
    if (empty_q || sum > high_sum_q) begin
      upd.high_place = place;
      upd.high_color = pixel_i;
      high_sum_d     = sum;
    end
    upd.low_place = low_place_q;
    upd.low_color = low_color_q;
    low_sum_d     = low_sum_q;
    if (empty_q || sum < low_sum_q) begin
      upd.low_place = place;
      upd.low_color = pixel_i;
      low_sum_d     = sum;
    end
    for (int c = 0; c < 3; c++) begin
      upd.chan_max[c] = (pixel_i[c] > max_q[c]) ? pixel_i[c] : max_q[c];
      upd.chan_min[c] = (pixel_i[c] < min_q[c]) ? pixel_i[c] : min_q[c];
    end

    row_d = row_q;
    if (col_inc >= width_eff) begin
      col_d = '0;
      row_d = (row_q == RowLast) ? '0 : row_q + CoordW'(1);
    end else begin
      col_d = col_inc[CoordW-1:0];
    end
    empty_d      = 1'b0;
    high_place_d = upd.high_place;
    high_color_d = upd.high_color;
    low_place_d  = upd.low_place;
    low_color_d  = upd.low_color;
    max_d        = upd.chan_max;
    min_d        = upd.chan_min;

    // Drop the frame once its last pixel is taken
    if (last_i) begin
      empty_d      = 1'b1;
      col_d        = '0;
      row_d        = '0;
      high_sum_d   = '0;
      low_sum_d    = '0;
      high_place_d = '0;
      high_color_d = '0;
      low_place_d  = '0;
      low_color_d  = '0;
      max_d        = '0;
      min_d        = {3{ChanFull}};
    end
  end

  assign report_o = upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q      <= 1'b1;
      col_q        <= '0;
      row_q        <= '0;
      high_sum_q   <= '0;
      low_sum_q    <= '0;
      high_place_q <= '0;
      high_color_q <= '0;
      low_place_q  <= '0;
      low_color_q  <= '0;
      max_q        <= '0;
      min_q        <= {3{ChanFull}};
    end else if (take_i) begin
      empty_q      <= empty_d;
      col_q        <= col_d;
      row_q        <= row_d;
      high_sum_q   <= high_sum_d;
      low_sum_q    <= low_sum_d;
      high_place_q <= high_place_d;
      high_color_q <= high_color_d;
      low_place_q  <= low_place_d;
      low_color_q  <= low_color_d;
      max_q        <= max_d;
      min_q        <= min_d;
    end
  end

endmodule

// File: verif/tb_image_extrema_statistics.sv
// Testbench for image_extrema_statistics: streams RGB frames and checks each report record
// against a frame statistics predictor held in a small scoreboard class.
// Depends on ies_pkg and the image_extrema_statistics RTL.
`timescale 1ns / 1ps

module tb_image_extrema_statistics;
  import ies_pkg::*;

  localparam int QuietLimit = 2000;

  typedef struct packed {
    ies_kind_e         kind;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic              last;
  } report_rec_t;

  class extrema_scoreboard;
    logic [CfgW-1:0]   width_reg;
    bit                empty;
    int unsigned       column;
    int unsigned       row;
    logic [SumW-1:0]   high_sum;
    logic [SumW-1:0]   low_sum;
    logic [CoordW-1:0] high_x, high_y, low_x, low_y;
    ies_color_t        high_color, low_color, chan_max, chan_min;
    report_rec_t       pending_records[$];
    int                errors;

    function new();
      width_reg = WidthReset;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      empty = 1'b1;
      column = 0;
      row = 0;
      high_sum = '0;
      low_sum = '0;
      high_x = '0;
      high_y = '0;
      low_x = '0;
      low_y = '0;
      high_color = '0;
      low_color = '0;
      for (int c = 0; c < 3; c++) begin
        chan_max[c] = '0;
        chan_min[c] = ChanFull;
      end
    endfunction

    function void fold_pixel(ies_color_t px, logic last);
      logic [SumW-1:0] sum;
      int unsigned span;
      sum = SumW'(px[0]) + SumW'(px[1]) + SumW'(px[2]);
      if (empty || sum > high_sum) begin
        high_sum = sum;
        high_x = CoordW'(column);
        high_y = CoordW'(row);
        high_color = px;
      end
      if (empty || sum < low_sum) begin
        low_sum = sum;
        low_x = CoordW'(column);
        low_y = CoordW'(row);
        low_color = px;
      end
      for (int c = 0; c < 3; c++) begin
        if (px[c] < chan_min[c]) chan_min[c] = px[c];
        if (px[c] > chan_max[c]) chan_max[c] = px[c];
      end
      empty = 1'b0;
      span = (width_reg == 0) ? 1 : ((width_reg > WidthCap) ? MaxWidth : width_reg);
      if (column + 1 >= span) begin
        column = 0;
        row = (row + 1 >= MaxHeight) ? 0 : row + 1;
      end else begin
        column++;
      end
      if (last) begin
        pending_records.push_back('{KindHighSum, high_x, high_y,
                                    high_color[0], high_color[1], high_color[2], 1'b0});
        pending_records.push_back('{KindLowSum, low_x, low_y,
                                    low_color[0], low_color[1], low_color[2], 1'b0});
        pending_records.push_back('{KindChanMax, '0, '0,
                                    chan_max[0], chan_max[1], chan_max[2], 1'b0});
        pending_records.push_back('{KindChanMin, '0, '0,
                                    chan_min[0], chan_min[1], chan_min[2], 1'b1});
        clear_frame();
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_record(report_rec_t got);
      report_rec_t want;
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_records.pop_front();
      compare_field("record_kind", want.kind, got.kind);
      compare_field("pos_x", want.x, got.x);
      compare_field("pos_y", want.y, got.y);
      compare_field("out_red", want.red, got.red);
      compare_field("out_green", want.green, got.green);
      compare_field("out_blue", want.blue, got.blue);
      compare_field("last_record", want.last, got.last);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CfgW-1:0]   cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [ChanW-1:0]  red_i, green_i, blue_i;
  logic              last_pixel_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        record_kind_o;
  logic [CoordW-1:0] pos_x_o, pos_y_o;
  logic [ChanW-1:0]  out_red_o, out_green_o, out_blue_o;
  logic              last_record_o;

  extrema_scoreboard sb;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                quiet_cycles;

  image_extrema_statistics dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .last_pixel_i (last_pixel_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .record_kind_o(record_kind_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .last_record_o(last_record_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_record('{ies_kind_e'(record_kind_o), pos_x_o, pos_y_o,
                          out_red_o, out_green_o, out_blue_o, last_record_o});
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_image_extrema_statistics NOT OK");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
      out_ready_i <= 1'b0;
    end
  end

  task automatic send_pixel(input logic [ChanW-1:0] r, g, b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    red_i        <= r;
    green_i      <= g;
    blue_i       <= b;
    last_pixel_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.fold_pixel({b, g, r}, last);
  endtask

  task automatic wait_for_reports();
    in_valid_i <= 1'b0;
    while (sb.pending_records.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [CfgW-1:0] value);
    wait_for_reports();
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.width_reg = value;
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random_pixels(input int count);
    logic [ChanW-1:0] r, g, b;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: {r, g, b} = '0;
        1: {r, g, b} = '1;
        2: begin
          case ($urandom_range(2))
            0: {r, g, b} = {8'd10, 8'd20, 8'd30};
            1: {r, g, b} = {8'd30, 8'd20, 8'd10};
            default: {r, g, b} = {8'd20, 8'd20, 8'd20};
          endcase
        end
        default: begin
          r = ChanW'($urandom_range(255));
          g = ChanW'($urandom_range(255));
          b = ChanW'($urandom_range(255));
        end
      endcase
      send_pixel(r, g, b, $urandom_range(7) == 0);
    end
  endtask

  initial begin
    int phase_send[4];
    int phase_recv[4];
    logic [CfgW-1:0] phase_width[4];
    phase_send  = '{0, 83, 0, 7};
    phase_recv  = '{0, 0, 83, 7};
    phase_width = '{13'd1, 13'd4096, 13'd3, 13'd4097};
    sb = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    red_i        <= '0;
    green_i      <= '0;
    blue_i       <= '0;
    last_pixel_i <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd10, 8'd20, 8'd30, 1'b0);
    send_pixel(8'd30, 8'd20, 8'd10, 1'b0);
    send_pixel(8'd20, 8'd20, 8'd20, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd254, 8'd254, 8'd254, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd1, 1'b1);
    write_width(13'd0);
    send_pixel(8'd5, 8'd6, 8'd7, 1'b0);
    send_pixel(8'd8, 8'd9, 8'd10, 1'b0);
    send_pixel(8'd3, 8'd3, 8'd3, 1'b1);
    write_width(13'd2);
    send_pixel(8'd1, 8'd1, 8'd1, 1'b0);
    send_pixel(8'd2, 8'd2, 8'd2, 1'b0);
    send_pixel(8'd3, 8'd3, 8'd3, 1'b0);
    send_pixel(8'd4, 8'd4, 8'd4, 1'b0);
    send_pixel(8'd100, 8'd0, 8'd0, 1'b0);
    write_width(13'd1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd200, 8'd200, 8'd200, 1'b1);

    for (int p = 0; p < 4; p++) begin
      write_width(phase_width[p]);
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      send_random_pixels(26);
      write_width(($urandom_range(3) == 0) ? CfgW'($urandom_range(8191))
                                           : CfgW'($urandom_range(12)));
      send_random_pixels(26);
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_pixel(8'd128, 8'd64, 8'd32, 1'b1);

    wait_for_reports();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_image_extrema_statistics OK");
    end else begin
      $display("tb_image_extrema_statistics NOT OK");
    end
    $finish;
  end

endmodule
